@@ sv/fisr_pkg.sv @@
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared types, constants and a leading-zero count helper for the reciprocal square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fisr_pkg;

	localparam logic [31:0] MAGIC     = 32'h5F3759DF;
	localparam logic [31:0] FP_HALF   = 32'h3F000000;
	localparam logic [31:0] FP_1P5    = 32'h3FC00000;
	localparam logic [31:0] CANON_NAN = 32'h7FC00000;
	localparam int          Y_DEPTH   = 12;

	typedef enum logic [1:0] {
		CLS_NUM  = 2'd0,
		CLS_ZERO = 2'd1,
		CLS_INF  = 2'd2,
		CLS_NAN  = 2'd3
	} fp_cls_t;

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic       found;
		n     = 6'd48;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found && v[i]) begin
				n     = 6'(47 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

@@ sv/fisr_in_if.sv @@
// ----------------------------------------------------------------------------
// fisr_in_if
// Operand channel: valid/ready handshake with raw binary32 payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface fisr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] operand_bits;

	modport source(output valid, output operand_bits, input ready);
	modport sink(input valid, input operand_bits, output ready);
endinterface

`default_nettype wire

@@ sv/fisr_out_if.sv @@
// ----------------------------------------------------------------------------
// fisr_out_if
// Result channel: valid/ready handshake with raw binary32 payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface fisr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;

	modport source(output valid, output result_bits, input ready);
	modport sink(input valid, input result_bits, output ready);
endinterface

`default_nettype wire

@@ sv/fisr_mul.sv @@
// ----------------------------------------------------------------------------
// fisr_mul
// Three-stage binary32 multiplier, round to nearest even, gradual underflow.
// ----------------------------------------------------------------------------
`default_nettype none

module fisr_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic             out_valid,
	output logic [31:0]      p
);

	logic [7:0]  ea, eb, eae, ebe;
	logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
	fisr_pkg::fp_cls_t cls_c;

	logic               v_s1, v_s2, v_s3;
	logic [47:0]        prod_s1;
	logic signed [10:0] exp_s1;
	logic               sign_s1, sign_s2;
	fisr_pkg::fp_cls_t  cls_s1, cls_s2;
	logic [47:0]        norm_s2;
	logic signed [10:0] exp_s2;
	logic [31:0]        p_s3;

	logic [5:0]         lz;
	logic signed [10:0] rsh_full;
	logic [5:0]         rsh;
	logic [47:0]        shifted, mask, n;
	logic               stk, rnd;
	logic [7:0]         ef;
	logic [30:0]        word;
	logic [31:0]        res_c;

	always_comb begin
		ea     = a[30:23];
		eb     = b[30:23];
		eae    = (ea == 8'd0) ? 8'd1 : ea;
		ebe    = (eb == 8'd0) ? 8'd1 : eb;
		a_nan  = (&ea) && (|a[22:0]);
		b_nan  = (&eb) && (|b[22:0]);
		a_inf  = (&ea) && !(|a[22:0]);
		b_inf  = (&eb) && !(|b[22:0]);
		a_zero = !(|a[30:0]);
		b_zero = !(|b[30:0]);
		if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
			cls_c = fisr_pkg::CLS_NAN;
		end else if (a_inf || b_inf) begin
			cls_c = fisr_pkg::CLS_INF;
		end else if (a_zero || b_zero) begin
			cls_c = fisr_pkg::CLS_ZERO;
		end else begin
			cls_c = fisr_pkg::CLS_NUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {24'd0, (ea != 8'd0), a[22:0]} * {24'd0, (eb != 8'd0), b[22:0]};
			exp_s1  <= $signed({3'd0, eae}) + $signed({3'd0, ebe}) - 11'sd126;
			sign_s1 <= a[31] ^ b[31];
			cls_s1  <= cls_c;
		end
	end

	assign lz = fisr_pkg::lzc48(prod_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s2 <= prod_s1 << lz;
			exp_s2  <= exp_s1 - $signed({5'd0, lz});
			sign_s2 <= sign_s1;
			cls_s2  <= cls_s1;
		end
	end

	always_comb begin
		rsh_full = 11'sd1 - exp_s2;
		rsh      = (rsh_full > 11'sd48) ? 6'd48 : rsh_full[5:0];
		shifted  = norm_s2 >> rsh;
		mask     = (48'd1 << rsh) - 48'd1;
		stk      = 1'b0;
		n        = norm_s2;
		ef       = exp_s2[7:0];
		if (exp_s2 < 11'sd1) begin
			n   = shifted;
			stk = |(norm_s2 & mask);
			ef  = 8'd0;
		end
		rnd  = n[23] && ((|n[22:0]) || stk || n[24]);
		word = {ef, n[46:24]} + {30'd0, rnd};
		case (cls_s2)
			fisr_pkg::CLS_NAN:  res_c = fisr_pkg::CANON_NAN;
			fisr_pkg::CLS_INF:  res_c = {sign_s2, 8'hFF, 23'd0};
			fisr_pkg::CLS_ZERO: res_c = {sign_s2, 31'd0};
			default: begin
				if (exp_s2 >= 11'sd255) begin
					res_c = {sign_s2, 8'hFF, 23'd0};
				end else begin
					res_c = {sign_s2, word};
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= res_c;
		end
	end

	assign out_valid = v_s3;
	assign p         = p_s3;

endmodule

`default_nettype wire

@@ sv/fisr_add.sv @@
// ----------------------------------------------------------------------------
// fisr_add
// Three-stage binary32 adder, round to nearest even, gradual underflow.
// ----------------------------------------------------------------------------
`default_nettype none

module fisr_add (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic             out_valid,
	output logic [31:0]      s
);

	logic [31:0] big, sml;
	logic [7:0]  ebig, esml, ebe, ese, d;
	logic [23:0] mbig, msml;
	logic [49:0] wide;
	logic [26:0] al;
	logic        a_nan, b_nan, a_inf, b_inf;
	fisr_pkg::fp_cls_t cls_c;
	logic        isign_c;

	logic              v_s1, v_s2, v_s3;
	logic [26:0]       big_s1, al_s1;
	logic              sub_s1, sign_s1, zsign_s1, isign_s1;
	logic [7:0]        exp_s1;
	fisr_pkg::fp_cls_t cls_s1, cls_s2;
	logic [27:0]       sum_s2;
	logic [5:0]        sh_s2;
	logic [8:0]        exp_s2;
	logic              sign_s2, zsign_s2, isign_s2;
	logic [31:0]       s_s3;

	logic [27:0] sum_c;
	logic [5:0]  lz;
	logic [7:0]  lim;
	logic [5:0]  sh_c;
	logic [8:0]  e_c;
	logic [26:0] n;
	logic [7:0]  ef;
	logic        rnd;
	logic [30:0] word;
	logic [31:0] res_c;

	always_comb begin
		if (b[30:0] > a[30:0]) begin
			big = b;
			sml = a;
		end else begin
			big = a;
			sml = b;
		end
		ebig = big[30:23];
		esml = sml[30:23];
		ebe  = (ebig == 8'd0) ? 8'd1 : ebig;
		ese  = (esml == 8'd0) ? 8'd1 : esml;
		mbig = {(ebig != 8'd0), big[22:0]};
		msml = {(esml != 8'd0), sml[22:0]};
		d    = ebe - ese;
		wide = {msml, 26'd0} >> d;
		if (d >= 8'd50) begin
			al = {26'd0, |msml};
		end else begin
			al = {wide[49:24], |wide[23:0]};
		end
		a_nan = (&a[30:23]) && (|a[22:0]);
		b_nan = (&b[30:23]) && (|b[22:0]);
		a_inf = (&a[30:23]) && !(|a[22:0]);
		b_inf = (&b[30:23]) && !(|b[22:0]);
		isign_c = a_inf ? a[31] : b[31];
		if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
			cls_c = fisr_pkg::CLS_NAN;
		end else if (a_inf || b_inf) begin
			cls_c = fisr_pkg::CLS_INF;
		end else begin
			cls_c = fisr_pkg::CLS_NUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s1   <= {mbig, 3'd0};
			al_s1    <= al;
			sub_s1   <= a[31] ^ b[31];
			sign_s1  <= big[31];
			zsign_s1 <= a[31] & b[31];
			isign_s1 <= isign_c;
			exp_s1   <= ebe;
			cls_s1   <= cls_c;
		end
	end

	always_comb begin
		if (sub_s1) begin
			sum_c = {1'b0, big_s1} - {1'b0, al_s1};
		end else begin
			sum_c = {1'b0, big_s1} + {1'b0, al_s1};
		end
		lz  = fisr_pkg::lzc48({sum_c[26:0], 21'd0});
		lim = exp_s1 - 8'd1;
		if ({2'd0, lz} < lim) begin
			sh_c = lz;
		end else begin
			sh_c = lim[5:0];
		end
		if (sum_c[27]) begin
			e_c = {1'b0, exp_s1} + 9'd1;
		end else begin
			e_c = {1'b0, exp_s1} - {3'd0, sh_c};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2   <= sum_c;
			sh_s2    <= sh_c;
			exp_s2   <= e_c;
			sign_s2  <= sign_s1;
			zsign_s2 <= zsign_s1;
			isign_s2 <= isign_s1;
			cls_s2   <= cls_s1;
		end
	end

	always_comb begin
		if (sum_s2[27]) begin
			n = {sum_s2[27:2], sum_s2[1] | sum_s2[0]};
		end else begin
			n = sum_s2[26:0] << sh_s2;
		end
		ef   = n[26] ? exp_s2[7:0] : 8'd0;
		rnd  = n[2] && (n[1] || n[0] || n[3]);
		word = {ef, n[25:3]} + {30'd0, rnd};
		case (cls_s2)
			fisr_pkg::CLS_NAN: res_c = fisr_pkg::CANON_NAN;
			fisr_pkg::CLS_INF: res_c = {isign_s2, 8'hFF, 23'd0};
			default: begin
				if (sum_s2 == 28'd0) begin
					res_c = {zsign_s2, 31'd0};
				end else if (exp_s2 >= 9'd255) begin
					res_c = {sign_s2, 8'hFF, 23'd0};
				end else begin
					res_c = {sign_s2, word};
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s3 <= res_c;
		end
	end

	assign out_valid = v_s3;
	assign s         = s_s3;

endmodule

`default_nettype wire

@@ sv/fast_inverse_sqrt_float32.sv @@
// Pipeline: 15 register stages.
// Throughput: one operand per cycle unless the stall below holds; five 3-stage float units in a chain.
// Stall: the whole pipeline holds while a result waits and result.ready is low.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_float32
// Approximate reciprocal square root: integer seed plus one Newton step.
// ----------------------------------------------------------------------------
`default_nettype none

module fast_inverse_sqrt_float32 (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fisr_in_if.sink     operand,
	fisr_out_if.source  result
);

	logic        en;
	logic [31:0] x, seed;
	logic [31:0] y_q [fisr_pkg::Y_DEPTH];
	logic        v1, v2, v3, v4, v5;
	logic [31:0] half, t1, t2, sc, r;

	assign en            = !result.valid || result.ready;
	assign operand.ready = en;
	assign x             = operand.operand_bits;
	assign seed          = fisr_pkg::MAGIC - {1'b0, x[31:1]};

	always_ff @(posedge clk) begin
		if (en) begin
			y_q[0] <= seed;
			for (int i = 1; i < fisr_pkg::Y_DEPTH; i++) begin
				y_q[i] <= y_q[i-1];
			end
		end
	end

	fisr_mul u_half (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(operand.valid),
		.a(x), .b(fisr_pkg::FP_HALF), .out_valid(v1), .p(half)
	);

	fisr_mul u_ty (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v1),
		.a(half), .b(y_q[2]), .out_valid(v2), .p(t1)
	);

	fisr_mul u_tyy (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v2),
		.a(t1), .b(y_q[5]), .out_valid(v3), .p(t2)
	);

	fisr_add u_sub (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v3),
		.a(fisr_pkg::FP_1P5), .b({~t2[31], t2[30:0]}), .out_valid(v4), .s(sc)
	);

	fisr_mul u_ys (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v4),
		.a(y_q[11]), .b(sc), .out_valid(v5), .p(r)
	);

	assign result.valid       = v5;
	assign result.result_bits = r;

endmodule

`default_nettype wire

@@ sv/fisr_chk.sv @@
// ----------------------------------------------------------------------------
// fisr_chk
// Port-level checks for the reciprocal square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module fisr_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_bits
);

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (out_ready || !out_valid))
		else $error("operand ready does not track result stall");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bits))
		else $error("stalled result changed");

	a_nan_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_bits[30:23] == 8'hFF) && (out_bits[22:0] != 23'd0)
		|-> out_bits == fisr_pkg::CANON_NAN)
		else $error("non-canonical NaN on result");

	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

	a_handshake_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready, out_valid}))
		else $error("unknown handshake signal");

endmodule

bind fast_inverse_sqrt_float32 fisr_chk u_fisr_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(operand.valid),
	.in_ready(operand.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_bits(result.result_bits)
);

`default_nettype wire

@@ verif/tb_fast_inverse_sqrt_float32.sv @@
// ----------------------------------------------------------------------------
// tb_fast_inverse_sqrt_float32
// Self-checking bench for the reciprocal square root pipeline. An integer
// binary32 model (round to nearest even, gradual underflow) predicts each
// result. Operands are directed corner values, then random mixes, with random
// gaps on both channels, a long result stall and a full drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fast_inverse_sqrt_float32;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 40;

	logic clk;
	logic arst_n;

	fisr_in_if  operand_ch();
	fisr_out_if result_ch();

	fast_inverse_sqrt_float32 i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_ch),
		.result (result_ch)
	);

	logic [31:0] expected_rsqrt[$];
	int          mismatches;
	int          cycles;
	bit          gaps_on;
	int          hold_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------- binary32 model ----------------

	function automatic void fp_split(input logic [31:0] v, output fisr_pkg::fp_cls_t cls,
			output int ex, output logic [63:0] man);
		ex  = 0;
		man = '0;
		if (v[30:23] == 8'hFF)
			cls = (v[22:0] != 0) ? fisr_pkg::CLS_NAN : fisr_pkg::CLS_INF;
		else if (v[30:0] == 0)
			cls = fisr_pkg::CLS_ZERO;
		else begin
			cls = fisr_pkg::CLS_NUM;
			if (v[30:23] == 0) begin
				man = {41'd0, v[22:0]};
				ex  = -149;
			end else begin
				man = {40'd0, 1'b1, v[22:0]};
				ex  = int'(v[30:23]) - 150;
			end
		end
	endfunction

	// value = man * 2^ex, rounded to nearest even
	function automatic logic [31:0] fp_round(input logic sgn, input int ex,
			input logic [63:0] man);
		int          p;
		int          sh;
		int          fld;
		logic [63:0] q;
		logic        g;
		logic        st;
		if (man == 0)
			return {sgn, 31'd0};
		p = 63;
		while (!man[p])
			p--;
		sh = (p + ex + 127 >= 1) ? p - 23 : -149 - ex;
		if (sh > 64) begin
			q  = '0;
			g  = 1'b0;
			st = 1'b1;
		end else if (sh > 0) begin
			q  = man >> sh;
			g  = man[sh-1];
			st = |(man & ((64'd1 << (sh - 1)) - 64'd1));
		end else begin
			q  = man << (-sh);
			g  = 1'b0;
			st = 1'b0;
		end
		if (g && (st || q[0]))
			q++;
		ex = ex + sh;
		if (q[24]) begin
			q = q >> 1;
			ex++;
		end
		if (!q[23])
			return {sgn, 8'd0, q[22:0]};
		fld = ex + 150;
		if (fld >= 255)
			return {sgn, 8'hFF, 23'd0};
		return {sgn, fld[7:0], q[22:0]};
	endfunction

	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		fisr_pkg::fp_cls_t ca, cb;
		int                ea, eb;
		logic [63:0]       ma, mb;
		logic              sgn;
		fp_split(a, ca, ea, ma);
		fp_split(b, cb, eb, mb);
		sgn = a[31] ^ b[31];
		if (ca == fisr_pkg::CLS_NAN || cb == fisr_pkg::CLS_NAN)
			return fisr_pkg::CANON_NAN;
		if ((ca == fisr_pkg::CLS_INF && cb == fisr_pkg::CLS_ZERO) ||
				(ca == fisr_pkg::CLS_ZERO && cb == fisr_pkg::CLS_INF))
			return fisr_pkg::CANON_NAN;
		if (ca == fisr_pkg::CLS_INF || cb == fisr_pkg::CLS_INF)
			return {sgn, 8'hFF, 23'd0};
		if (ca == fisr_pkg::CLS_ZERO || cb == fisr_pkg::CLS_ZERO)
			return {sgn, 31'd0};
		return fp_round(sgn, ea + eb, ma * mb);
	endfunction

	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		fisr_pkg::fp_cls_t ca, cb;
		int                ea, eb, d, ex;
		logic [63:0]       ma, mb, big, sm;
		logic [31:0]       tmp;
		fp_split(a, ca, ea, ma);
		fp_split(b, cb, eb, mb);
		if (ca == fisr_pkg::CLS_NAN || cb == fisr_pkg::CLS_NAN)
			return fisr_pkg::CANON_NAN;
		if (ca == fisr_pkg::CLS_INF && cb == fisr_pkg::CLS_INF)
			return (a[31] != b[31]) ? fisr_pkg::CANON_NAN : a;
		if (ca == fisr_pkg::CLS_INF)
			return a;
		if (cb == fisr_pkg::CLS_INF)
			return b;
		if (ca == fisr_pkg::CLS_ZERO && cb == fisr_pkg::CLS_ZERO)
			return {a[31] & b[31], 31'd0};
		if (ca == fisr_pkg::CLS_ZERO)
			return b;
		if (cb == fisr_pkg::CLS_ZERO)
			return a;
		if (eb > ea) begin
			tmp = a; a = b; b = tmp;
			d = ea; ea = eb; eb = d;
			big = ma; ma = mb; mb = big;
		end
		d = ea - eb;
		if (d <= 40) begin
			big = ma << d;
			sm  = mb;
			ex  = eb;
		end else begin
			// far operand only contributes a sticky bit
			big = ma << 3;
			sm  = 64'd1;
			ex  = ea - 3;
		end
		if (a[31] == b[31])
			return fp_round(a[31], ex, big + sm);
		if (big > sm)
			return fp_round(a[31], ex, big - sm);
		if (sm > big)
			return fp_round(b[31], ex, sm - big);
		return 32'd0;
	endfunction

	function automatic logic [31:0] predict_rsqrt(input logic [31:0] x);
		logic [31:0] half, seed, t, s, y;
		half = fp_mul(x, fisr_pkg::FP_HALF);
		seed = fisr_pkg::MAGIC - (x >> 1);
		t    = fp_mul(half, seed);
		t    = fp_mul(t, seed);
		s    = fp_add(fisr_pkg::FP_1P5, {~t[31], t[30:0]});
		y    = fp_mul(seed, s);
		if (y[30:23] == 8'hFF && y[22:0] != 0)
			y = fisr_pkg::CANON_NAN;
		return y;
	endfunction

	// ---------------- channels ----------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %08h expected %08h at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	task automatic send_operand(input logic [31:0] x);
		logic rdy;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			operand_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		operand_ch.valid        <= 1'b1;
		operand_ch.operand_bits <= x;
		do begin
			@(negedge clk);
			rdy = operand_ch.ready;
			@(posedge clk);
		end while (!rdy);
		expected_rsqrt.push_back(predict_rsqrt(x));
	endtask

	always begin
		@(posedge clk);
		if (hold_cycles > 0) begin
			hold_cycles--;
			result_ch.ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			result_ch.ready <= 1'b0;
			repeat ($urandom_range(1, 17) - 1) @(posedge clk);
		end else
			result_ch.ready <= 1'b1;
	end

	always @(negedge clk) begin
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_rsqrt.size() == 0)
				report_mismatch("unexpected transfer", result_ch.result_bits, 32'h0);
			else if (result_ch.result_bits !== expected_rsqrt[0]) begin
				report_mismatch("result_bits", result_ch.result_bits, expected_rsqrt[0]);
				void'(expected_rsqrt.pop_front());
			end else
				void'(expected_rsqrt.pop_front());
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_fast_inverse_sqrt_float32 NOT OK");
			$finish;
		end
	end

	// ---------------- tests ----------------

	function automatic logic [31:0] random_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return {1'b0, 8'($urandom_range(90, 164)), 23'($urandom)};
			7:          return {1'($urandom), 8'd0, 23'($urandom)};
			8:          return {1'($urandom), 8'hFF, ($urandom_range(0, 1) ? 23'($urandom) : 23'd0)};
			default:    return {1'b1, 8'($urandom), 23'($urandom)};
		endcase
	endfunction

	task automatic test_corners();
		logic [31:0] corners[$];
		corners = {32'h00000000, 32'h80000000, 32'h00000001, 32'h007FFFFF,
			32'h00800000, 32'h3F800000, 32'h40800000, 32'h3E800000,
			32'h7F7FFFFF, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
			32'h7F800001, 32'hFFFFFFFF, 32'hBF800000, 32'h80000001,
			32'h807FFFFF, 32'hFF7FFFFF, 32'h5F3759DF, 32'hBE6EB3BE,
			32'h3F000000, 32'h42C80000, 32'h0000FFFF};
		foreach (corners[i])
			send_operand(corners[i]);
	endtask

	task automatic test_output_stall();
		hold_cycles = 300;
		for (int i = 0; i < 80; i++)
			send_operand(random_operand());
	endtask

	task automatic test_drain_pause();
		operand_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_rsqrt.size() != 0)
			@(posedge clk);
		send_operand(32'h3F800000);
	endtask

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++)
			send_operand(random_operand());
	endtask

	task automatic test_streaming(input int count);
		gaps_on = 1'b0;
		for (int i = 0; i < count; i++)
			send_operand(random_operand());
	endtask

	initial begin
		arst_n                  = 1'b0;
		operand_ch.valid        = 1'b0;
		operand_ch.operand_bits = '0;
		result_ch.ready         = 1'b0;
		mismatches              = 0;
		cycles                  = 0;
		gaps_on                 = 1'b1;
		hold_cycles             = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_output_stall();
		test_drain_pause();
		test_random_mix(1300);
		test_streaming(300);

		operand_ch.valid <= 1'b0;
		while (expected_rsqrt.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("tb_fast_inverse_sqrt_float32 OK");
		else
			$display("tb_fast_inverse_sqrt_float32 NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
